// File: rtl/racr_pkg.sv
// package: widths, op codes and controller command/status types
`timescale 1ns / 1ps
package racr_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_CMP = 2'd1;
    localparam logic [1:0] OP_NORM = 2'd2;

    typedef struct packed {
        logic load;
        logic prep;
        logic form;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip_reduce;
        logic gcd_done;
        logic div_done;
    } t_status;
endpackage

// File: rtl/racr_if.sv
// valid/ready stream interfaces for the input and result channels
`timescale 1ns / 1ps
interface racr_in_if #(parameter int W = racr_pkg::OPERAND_WIDTH);
    logic valid;
    logic ready;
    logic [1:0] op;
    logic signed [W-1:0] first_num;
    logic signed [W-1:0] first_den;
    logic signed [W-1:0] second_num;
    logic signed [W-1:0] second_den;
    modport source(output valid, op, first_num, first_den, second_num, second_den,
                   input ready);
    modport sink(input valid, op, first_num, first_den, second_num, second_den,
                 output ready);
endinterface

interface racr_out_if;
    logic valid;
    logic ready;
    logic signed [racr_pkg::NUM_W-1:0] result_num;
    logic [racr_pkg::DEN_W-1:0] result_den;
    logic is_equal;
    logic is_greater;
    logic is_less;
    modport source(output valid, result_num, result_den, is_equal, is_greater, is_less,
                   input ready);
    modport sink(input valid, result_num, result_den, is_equal, is_greater, is_less,
                 output ready);
endinterface

// File: rtl/racr_datapath.sv
// datapath: operand prep, cross products, binary gcd, restoring division
`timescale 1ns / 1ps
module racr_datapath #(
    parameter int OPERAND_WIDTH = racr_pkg::OPERAND_WIDTH
) (
    input  logic                              i_clk,
    input  racr_pkg::t_cmd                    i_cmd,
    input  logic [1:0]                        i_op,
    input  logic signed [OPERAND_WIDTH-1:0]   i_n1,
    input  logic signed [OPERAND_WIDTH-1:0]   i_d1,
    input  logic signed [OPERAND_WIDTH-1:0]   i_n2,
    input  logic signed [OPERAND_WIDTH-1:0]   i_d2,
    output racr_pkg::t_status                 o_status,
    output logic signed [racr_pkg::NUM_W-1:0] o_num,
    output logic [racr_pkg::DEN_W-1:0]        o_den,
    output logic                              o_eq,
    output logic                              o_gt,
    output logic                              o_lt
);
    localparam int PW = OPERAND_WIDTH + 1;
    localparam int MW = 2 * PW;
    localparam int SW = MW + 1;
    localparam int CW = $clog2(SW + 1);

    logic [1:0] r_op;
    logic signed [OPERAND_WIDTH-1:0] r_in1, r_id1, r_in2, r_id2;
    logic signed [PW-1:0] r_n1, r_d1, r_n2, r_d2;
    logic signed [SW-1:0] r_num;
    logic [SW-1:0] r_den, r_a, r_b, r_mag, r_q, r_rem, r_dvs;
    logic r_neg, r_qsel;
    logic [CW-1:0] r_sh, r_cnt;
    logic [1:0] r_pass;
    // magnitude loaded in the cycle after form, gcd operands on the first step
    logic r_gload;
    logic r_gfirst;

    function automatic void prep(input logic signed [OPERAND_WIDTH-1:0] n,
                                 input logic signed [OPERAND_WIDTH-1:0] d,
                                 output logic signed [PW-1:0] on,
                                 output logic signed [PW-1:0] od);
        logic signed [PW-1:0] en, ed;
        en = PW'(n);
        ed = (d == '0) ? PW'(1) : PW'(d);
        if (ed < 0) begin
            on = -en;
            od = -ed;
        end else begin
            on = en;
            od = ed;
        end
    endfunction

    logic signed [MW-1:0] p_a, p_b;
    logic signed [SW-1:0] sum;
    logic [SW-1:0] a_sub, b_sub, trial;
    assign p_a = MW'(r_n1) * MW'(r_d2);
    assign p_b = MW'(r_d1) * MW'(r_n2);
    assign sum = SW'(p_a) + SW'(p_b);
    assign a_sub = r_a - r_b;
    assign b_sub = r_b - r_a;
    assign trial = {r_rem[SW-2:0], r_q[SW-1]} - r_dvs;

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] t1, t2, t3, t4;
        if (i_cmd.load) begin
            r_op <= i_op;
            r_in1 <= i_n1; r_id1 <= i_d1; r_in2 <= i_n2; r_id2 <= i_d2;
        end
        if (i_cmd.prep) begin
            prep(r_in1, r_id1, t1, t2);
            prep(r_in2, r_id2, t3, t4);
            r_n1 <= t1; r_d1 <= t2; r_n2 <= t3; r_d2 <= t4;
        end
        if (i_cmd.form) begin
            o_eq <= 1'b0; o_gt <= 1'b0; o_lt <= 1'b0;
            if (r_op == racr_pkg::OP_ADD) begin
                r_num <= sum;
                r_den <= SW'(MW'(r_d1) * MW'(r_d2));
            end else if (r_op == racr_pkg::OP_NORM) begin
                r_num <= SW'(r_n1);
                r_den <= SW'(r_d1);
            end else begin
                r_num <= '0;
                r_den <= SW'(1);
                if (r_op == racr_pkg::OP_CMP) begin
                    o_eq <= p_a == p_b;
                    o_gt <= p_a > p_b;
                    o_lt <= p_a < p_b;
                end
            end
            r_sh <= '0;
        end
        if (r_gload) begin
            r_neg <= r_num < 0;
            r_mag <= (r_num < 0) ? SW'(-r_num) : SW'(r_num);
        end
        if (i_cmd.gcd_step && !o_status.gcd_done) begin
            if (r_gfirst) begin
                r_a <= r_mag;
                r_b <= r_den;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1; r_b <= r_b >> 1; r_sh <= r_sh + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= a_sub >> 1;
            end else begin
                r_b <= b_sub >> 1;
            end
        end else if (i_cmd.form) begin
            r_a <= '0;
            r_b <= '0;
        end
        if (i_cmd.div_init || (i_cmd.div_step && r_cnt == '0 && r_pass == 2'd1)) begin
            r_cnt <= CW'(SW);
            r_rem <= '0;
            r_qsel <= (i_cmd.div_init) ? 1'b0 : 1'b1;
            r_q <= i_cmd.div_init ? r_mag : r_den;
            r_dvs <= (r_a | r_b) << r_sh;
            r_pass <= i_cmd.div_init ? 2'd1 : 2'd2;
        end else if (i_cmd.div_step && r_cnt != '0) begin
            if (!trial[SW-1]) begin
                r_rem <= trial;
                r_q <= {r_q[SW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SW-2:0], r_q[SW-1]};
                r_q <= {r_q[SW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                if (r_qsel) r_den <= {r_q[SW-2:0], !trial[SW-1]};
                else r_mag <= {r_q[SW-2:0], !trial[SW-1]};
            end
        end
        if (i_cmd.finish) begin
            if (r_num == '0) begin
                o_num <= '0;
                o_den <= racr_pkg::DEN_W'(1);
            end else begin
                o_num <= r_neg ? -(racr_pkg::NUM_W'(r_mag)) : racr_pkg::NUM_W'(r_mag);
                o_den <= r_den[racr_pkg::DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gload <= i_cmd.form;
        r_gfirst <= r_gload;
    end

    logic [SW-1:0] ga, gb;
    assign ga = r_a;
    assign gb = r_b;

    assign o_status.skip_reduce = (r_num == '0) ||
                                  !(r_op == racr_pkg::OP_ADD || r_op == racr_pkg::OP_NORM);
    assign o_status.gcd_done = !r_gfirst && (ga == '0 || gb == '0);
    assign o_status.div_done = (r_cnt == '0) && (r_pass == 2'd2);
endmodule

// File: rtl/racr_ctrl.sv
// controller: sequences load, prep, form, gcd, the two divisions, finish and output
`timescale 1ns / 1ps
module racr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  racr_pkg::t_status i_status,
    output racr_pkg::t_cmd    o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_PREP = 8'b00000010,
        S_FORM = 8'b00000100,
        S_LOAD = 8'b00001000,
        S_GCD  = 8'b00010000,
        S_DIV  = 8'b00100000,
        S_FIN  = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;
    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin o_cmd.prep = 1'b1; n_state = S_FORM; end
            S_FORM: begin o_cmd.form = 1'b1; n_state = S_LOAD; end
            S_LOAD: n_state = i_status.skip_reduce ? S_FIN : S_GCD;
            S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_status.gcd_done) begin
                    o_cmd.gcd_step = 1'b0;
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_FIN;
            end
            S_FIN: begin o_cmd.finish = 1'b1; n_state = S_OUT; end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while result pending");
endmodule

// File: rtl/rational_add_compare_reduce_core.sv
// top level: fraction add, compare and normalize with gcd reduction
`timescale 1ns / 1ps
// usage:
//   i_in carries op and two signed fractions; a zero denominator counts as one.
//   o_out returns one result per transfer: reduced fraction for add and
//   normalize, flags for compare (fraction 0/1 then).
//   one item at a time: in_ready is high only when the block is idle.
//   for compare, spare op or a zero numerator the controller goes from the
//   input transfer through prep, form, load and finish to the output state;
//   add and normalize add a binary gcd loop and two restoring divisions of
//   35 quotient bits each on the shared divider.
//   a stalled receiver holds the result in the output register; no new
//   input is taken until it is transferred.
//   reset (synchronous, active low) returns the controller to idle.
module rational_add_compare_reduce_core #(
    parameter int OPERAND_WIDTH = racr_pkg::OPERAND_WIDTH
) (
    input logic i_clk,
    input logic i_rst_n,
    racr_in_if.sink i_in,
    racr_out_if.source o_out
);
    racr_pkg::t_cmd cmd;
    racr_pkg::t_status status;

    racr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_status(status), .o_cmd(cmd)
    );

    racr_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_op(i_in.op),
        .i_n1(i_in.first_num[OPERAND_WIDTH-1:0]), .i_d1(i_in.first_den[OPERAND_WIDTH-1:0]),
        .i_n2(i_in.second_num[OPERAND_WIDTH-1:0]), .i_d2(i_in.second_den[OPERAND_WIDTH-1:0]),
        .o_status(status), .o_num(o_out.result_num), .o_den(o_out.result_den),
        .o_eq(o_out.is_equal), .o_gt(o_out.is_greater), .o_lt(o_out.is_less)
    );
endmodule
